### src/b2ad_pkg.sv
package b2ad_pkg;

    localparam int VALUE_W    = 31;
    localparam int CHAR_W     = 6;
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 10;
    localparam int DIG_IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

    // floor(v / 10) == (v * RECIP_TEN) >> RECIP_SHIFT for every v below 2**32
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          PROD_W      = VALUE_W + 32;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } b2ad_req_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_GEN,
        B_EMIT
    } b2ad_state_t;

endpackage

### src/binary_to_ascii_decimal_unit.sv
// Channel | Handshake          | Payload
// --------+--------------------+----------------------------------
// in      | in_valid/in_ready  | value[30:0]
// out     | out_valid/out_ready| digit_char[5:0], last_digit
//
// The back end picks each request up from the queue, makes one divide-by-ten
// step per digit through the single reciprocal multiplier, then drains the
// digit store MSB first (at most ten digits), waiting while the output is
// stalled. A two-entry queue keeps taking requests while the back end works
// or the output is stalled, as long as it has room. Reset empties the queue,
// idles the back end and clears out_valid; nothing else needs clearing.
module binary_to_ascii_decimal_unit
    import b2ad_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAR_W-1:0]  digit_char,
    output logic               last_digit
);

    b2ad_req_t req;
    logic      pop;

    b2ad_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .value    (value),
        .req      (req),
        .pop      (pop)
    );

    b2ad_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

endmodule

### src/b2ad_front.sv
module b2ad_front
    import b2ad_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] value,
    output b2ad_req_t          req,
    input  logic               pop
);

    logic [VALUE_W-1:0] entry_reg [QUEUE_DEPTH];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               push;
    logic               do_pop;

    assign in_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign do_pop   = pop && (cnt_reg != 2'd0);

    assign req.valid = (cnt_reg != 2'd0);
    assign req.value = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= value;
        end
    end

endmodule

### src/b2ad_back.sv
module b2ad_back
    import b2ad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  b2ad_req_t         req,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] digit_char,
    output logic              last_digit
);

    b2ad_state_t        state_reg, state_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [DIG_IDX_W-1:0] cnt_reg, cnt_next;
    logic [DIG_IDX_W-1:0] idx_reg, idx_next;
    logic [DIGIT_W-1:0] rev_reg [MAX_DIGITS];
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;

    logic [PROD_W-1:0]  prod;
    logic [VALUE_W-1:0] quot;
    logic [VALUE_W-1:0] quot_x10;
    logic [DIGIT_W-1:0] rem;
    logic               gen_done;
    logic               load;
    logic               gen_en;

    // one digit per cycle: reciprocal multiply, remainder from v - 10q
    assign prod     = PROD_W'(val_reg) * PROD_W'(RECIP_TEN);
    assign quot     = VALUE_W'(prod >> RECIP_SHIFT);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem      = DIGIT_W'(val_reg - quot_x10);
    assign gen_done = (quot == '0) || (cnt_reg == DIG_IDX_W'(MAX_DIGITS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = B_GEN;
                end
            end
            B_GEN:
            begin
                if (gen_done)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (load && (idx_reg == '0))
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        pop    = 1'b0;
        gen_en = 1'b0;
        load   = 1'b0;
        case (state_reg)
            B_IDLE: pop    = req.valid;
            B_GEN:  gen_en = 1'b1;
            B_EMIT: load   = !out_valid_reg || out_ready;
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        val_next       = val_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (pop)
        begin
            val_next = req.value;
            cnt_next = '0;
        end
        if (gen_en)
        begin
            val_next = quot;
            cnt_next = cnt_reg + DIG_IDX_W'(1);
            idx_next = cnt_reg;
        end
        if (load)
        begin
            // most significant digit sits at the highest filled slot
            char_next      = ASCII_ZERO + CHAR_W'(rev_reg[idx_reg]);
            last_next      = (idx_reg == '0);
            out_valid_next = 1'b1;
            idx_next       = idx_reg - DIG_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
        if (gen_en)
        begin
            rev_reg[cnt_reg] <= rem;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;

endmodule

### verif/decimal_digit_checker.sv
`timescale 1ns / 100ps

module decimal_digit_checker
    import b2ad_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [VALUE_W-1:0] value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [CHAR_W-1:0]  digit_char,
    input  logic               last_digit,
    output int                 fail_count,
    output int                 pending
);

    localparam int unsigned DECIMAL_BASE = 10;
    localparam int          DIGIT_CAP    = 20;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_exp_t;

    digit_exp_t digits_due[$];

    // Queue up the decimal digits of one request, most significant first
    function automatic void predict_digits(logic [VALUE_W-1:0] v);
        logic [31:0] rest;
        logic [3:0]  rev[DIGIT_CAP];
        int          lim;
        int          n;
        lim  = MAX_DIGITS;
        if (lim < 1)
            lim = 1;
        if (lim > DIGIT_CAP)
            lim = DIGIT_CAP;
        rest = 32'(v);
        n    = 0;
        do
        begin
            rev[n] = 4'(rest % DECIMAL_BASE);
            rest   = rest / DECIMAL_BASE;
            n++;
        end
        while (rest != 0 && n < lim);
        for (int k = 0; k < n; k++)
            digits_due.push_back('{ch: CHAR_W'(ASCII_ZERO + CHAR_W'(rev[n - 1 - k])),
                                   last: (k == n - 1)});
    endfunction

    always @(posedge clk)
    begin
        digit_exp_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (digits_due.size() == 0)
                begin
                    $display("%0t: unexpected digit: char %0d last %0b",
                             $time, digit_char, last_digit);
                    fail_count++;
                end
                else
                begin
                    want = digits_due.pop_front();
                    if (digit_char !== want.ch)
                    begin
                        $display("%0t: digit_char mismatch: expected %0d actual %0d",
                                 $time, want.ch, digit_char);
                        fail_count++;
                    end
                    if (last_digit !== want.last)
                    begin
                        $display("%0t: last_digit mismatch: expected %0b actual %0b",
                                 $time, want.last, last_digit);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_digits(value);
            pending = digits_due.size();
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import b2ad_pkg::*;

    localparam int          RANDOM_ITEMS = 480;
    localparam int          PAUSE_AT     = 240;
    localparam int unsigned HOLD_START   = 2500;
    localparam int unsigned HOLD_LEN     = 400;
    localparam int unsigned MODE_SPAN    = 150;
    localparam int unsigned VALUE_MAX    = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_PATTERN,
        RX_STARVED
    } rx_mode_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [VALUE_W-1:0] value;
    logic               out_valid;
    logic               out_ready;
    logic [CHAR_W-1:0]  digit_char;
    logic               last_digit;
    int                 fail_count;
    int                 pending;

    binary_to_ascii_decimal_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    decimal_digit_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last_digit (last_digit),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
        clk = 1'b0;

    always #4 clk = ~clk;

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(logic [VALUE_W-1:0] v);
        in_valid = 1'b1;
        value    = v;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic idle_for(int unsigned cycles);
        in_valid = 1'b0;
        value    = VALUE_W'($urandom);
        repeat (cycles)
            @(negedge clk);
    endtask

    // Mostly uniform over digit count, some fully random words
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned ndig;
        int unsigned lo;
        int unsigned hi;
        if ($urandom_range(0, 7) == 0)
            return VALUE_W'($urandom);
        ndig = $urandom_range(1, 10);
        lo   = 1;
        for (int i = 1; i < ndig; i++)
            lo = lo * 10;
        hi   = (ndig == 10) ? VALUE_MAX : lo * 10 - 1;
        if (ndig == 1)
            lo = 0;
        return VALUE_W'($urandom_range(hi, lo));
    endfunction

    // Receiver: rotating stall patterns plus one long hold-off
    initial
    begin
        int unsigned tick;
        out_ready = 1'b0;
        tick      = 0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (tick >= HOLD_START && tick < HOLD_START + HOLD_LEN)
                out_ready = 1'b0;
            else
                case (rx_mode_t'(2'((tick / MODE_SPAN) % 4)))
                    RX_ALWAYS:  out_ready = 1'b1;
                    RX_COIN:    out_ready = 1'($urandom_range(0, 1));
                    RX_PATTERN: out_ready = (tick % 4) != 0;
                    default:    out_ready = ($urandom_range(0, 4) == 0);
                endcase
        end
    end

    initial
    begin
        int unsigned        directed[$];
        int                 sent;
        int unsigned        burst;
        in_valid = 1'b0;
        value    = '0;
        rst_n    = 1'b0;
        directed = '{0, 1, 9, 10, 11, 99, 100, 101, 1000, 99999, 100000,
                     1234567890, 999999999, 1000000000, 2000000000,
                     2147483647, 2147483640, 32'h2AAA_AAAA, 32'h5555_5555,
                     1000000001, 4294967, 65535, 65536, 500, 7};
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_request(VALUE_W'(directed[i]));
        idle_for(3);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && sent < RANDOM_ITEMS)
            begin
                send_request(pick_value());
                sent++;
                burst--;
                if (sent == PAUSE_AT)
                begin
                    // let the unit run completely dry
                    in_valid = 1'b0;
                    while (pending != 0)
                        @(negedge clk);
                    burst = 0;
                end
            end
            if ($urandom_range(0, 3) == 0)
                idle_for($urandom_range(4, 25));
            else if ($urandom_range(0, 1) == 0)
                idle_for($urandom_range(1, 3));
        end
        in_valid = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (40)
            @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
